>>> design/pbr_pkg.sv
// ----------------------------------------------------------------------------
// pbr_pkg: shared types and constants
// Control word carried through the rate pipeline, and fixed constants.
// ----------------------------------------------------------------------------
package pbr_pkg;

    localparam int QUO_W = 32;
    localparam logic [QUO_W-1:0] RATE_MAX = {QUO_W{1'b1}};
    // seconds-to-micros times milli scale: 1e6 * 1e3
    localparam logic [29:0] BILLION = 30'd1_000_000_000;
    localparam logic [7:0] ALPHABET_RESET = 8'd36;
    localparam logic [2:0] ADDR_ALPHABET = 3'd0;

    typedef struct packed {
        logic valid;
        logic zero;   // result forced to zero
        logic sat;    // quotient known to be at or above 2^32
    } pbr_ctl_t;

endpackage

>>> design/practical_bit_rate.sv
// ----------------------------------------------------------------------------
// practical_bit_rate: practical bit rate in millibits per second
// Pipelined log2 * net * 1e9 over elapsed * 2^F, rounded half up, saturated.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid / in_stall     | correct_count, incorrect_count,
//          |                         | elapsed_micros
//  out     | out_valid / out_stall   | millibits_per_second
//  cfg     | APB psel/penable/pwrite | alphabet_size at byte address 0
//
//  One item per cycle unless a result waits on out_stall; stages: input capture, two
//  multiplier stages, numerator build, saturation compare, 32 division cells, output.
//  rst_n clears all valid bits and sets alphabet_size to 36.
//  The whole pipeline holds while a result waits on out_stall; in_stall is
//  raised only then, so a new item still enters behind a taken result.
// ----------------------------------------------------------------------------
module practical_bit_rate
    import pbr_pkg::*;
#(
    parameter int MIN_ALPHABET  = 2,
    parameter int LOG_FRAC_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] correct_count,
    input  logic [15:0] incorrect_count,
    input  logic [39:0] elapsed_micros,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] millibits_per_second,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW   = LOG_FRAC_BITS + 3;   // log2 value, 3 integer bits
    localparam int P1W  = LW + 16;             // log * net
    localparam int P2W  = P1W + 30;            // times 1e9
    localparam int DENW = 40 + LOG_FRAC_BITS;  // elapsed << F
    localparam int CW   = DENW + 34;           // room for 2*den << 32
    localparam int NC   = QUO_W;

    logic [LW-1:0] lg;
    logic          alpha_ok;
    logic          adv;

    pbr_cfg #(
        .MIN_ALPHABET  (MIN_ALPHABET),
        .LOG_FRAC_BITS (LOG_FRAC_BITS),
        .LW            (LW)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .lg       (lg),
        .alpha_ok (alpha_ok)
    );

    // all stages move together unless the output is held
    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // front stages
    pbr_ctl_t       c0_reg, c1_reg, c2_reg, c3_reg, c4_reg;
    logic [15:0]    net0_reg;
    logic [LW-1:0]  lg0_reg;
    logic [39:0]    el0_reg, el1_reg, el2_reg;
    logic [P1W-1:0] p1_reg;
    logic [P2W-1:0] p2_reg;
    logic [CW-1:0]  n3_reg, d3_reg, n4_reg, d4_reg;
    pbr_ctl_t       c0_next;

    always_comb
    begin
        c0_next.valid = in_valid;
        c0_next.zero  = !alpha_ok || (elapsed_micros == 40'd0)
                        || (correct_count <= incorrect_count);
        c0_next.sat   = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else if (adv)
        begin
            c0_reg <= c0_next;
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= '{valid: c3_reg.valid, zero: c3_reg.zero,
                        sat: (n3_reg >= (d3_reg << NC))};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            net0_reg <= correct_count - incorrect_count;
            lg0_reg  <= lg;
            el0_reg  <= elapsed_micros;
            p1_reg   <= P1W'(lg0_reg) * P1W'(net0_reg);
            el1_reg  <= el0_reg;
            p2_reg   <= P2W'(p1_reg) * P2W'(BILLION);
            el2_reg  <= el1_reg;
            // numerator 2*num + den, divisor 2*den: rounds half up
            n3_reg   <= (CW'(p2_reg) << 1) + (CW'(el2_reg) << LOG_FRAC_BITS);
            d3_reg   <= CW'(el2_reg) << (LOG_FRAC_BITS + 1);
            n4_reg   <= n3_reg;
            d4_reg   <= d3_reg;
        end
    end

    // division chain, quotient bit 31 first
    pbr_ctl_t         ctl_c [NC+1];
    logic [CW-1:0]    rem_c [NC+1];
    logic [CW-1:0]    den_c [NC+1];
    logic [QUO_W-1:0] quo_c [NC+1];

    assign ctl_c[0] = c4_reg;
    assign rem_c[0] = n4_reg;
    assign den_c[0] = d4_reg;
    assign quo_c[0] = '0;

    for (genvar j = 0; j < NC; j++)
    begin : g_cell
        pbr_div_cell #(
            .CW    (CW),
            .SHIFT (NC - 1 - j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (ctl_c[j]),
            .rem_in  (rem_c[j]),
            .den_in  (den_c[j]),
            .quo_in  (quo_c[j]),
            .ctl_out (ctl_c[j+1]),
            .rem_out (rem_c[j+1]),
            .den_out (den_c[j+1]),
            .quo_out (quo_c[j+1])
        );
    end

    // output register
    logic [31:0] rate_reg, rate_next;
    pbr_ctl_t    fin;

    always_comb
    begin
        fin = ctl_c[NC];
        if (fin.zero)
            rate_next = '0;
        else if (fin.sat || (quo_c[NC] == RATE_MAX))
            rate_next = RATE_MAX;
        else
            rate_next = quo_c[NC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= fin.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rate_reg <= rate_next;
    end

    assign out_valid            = out_valid_reg;
    assign millibits_per_second = rate_reg;

endmodule

>>> design/pbr_cfg.sv
// ----------------------------------------------------------------------------
// pbr_cfg: configuration register and log2 lookup
// Holds alphabet_size and the fixed-point log2(alphabet_size - 1).
// ----------------------------------------------------------------------------
module pbr_cfg
    import pbr_pkg::*;
#(
    parameter int MIN_ALPHABET  = 2,
    parameter int LOG_FRAC_BITS = 20,
    parameter int LW            = LOG_FRAC_BITS + 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output logic [LW-1:0] lg,
    output logic          alpha_ok
);

    typedef logic [LW-1:0] tbl_t [256];

    // log2 by repeated truncated squaring, built at elaboration
    function automatic tbl_t build_tbl();
        tbl_t        t;
        int          k;
        logic [63:0] x;
        logic [LW-1:0] fr;
        for (int m = 0; m < 256; m++)
        begin
            k = 0;
            for (int b = 1; b < 8; b++)
            begin
                if ((m >> b) != 0)
                    k = b;
            end
            x = (64'(m) << 31) >> k;
            fr = '0;
            for (int i = 0; i < LOG_FRAC_BITS; i++)
            begin
                x = (x * x) >> 31;
                fr = fr << 1;
                if (x >= (64'd1 << 32))
                begin
                    fr[0] = 1'b1;
                    x = x >> 1;
                end
            end
            t[m] = (LW'(k) << LOG_FRAC_BITS) | fr;
        end
        return t;
    endfunction

    localparam tbl_t LOG_TBL = build_tbl();

    logic [7:0]    alpha_reg;
    logic [LW-1:0] lg_reg;
    logic          ok_reg;
    logic          wr_en;
    logic [7:0]    wval;

    assign wr_en = psel && penable && pwrite && (paddr == ADDR_ALPHABET);
    assign wval  = pwdata[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHABET_RESET;
            lg_reg    <= LOG_TBL[ALPHABET_RESET - 8'd1];
            ok_reg    <= (ALPHABET_RESET >= 8'(MIN_ALPHABET));
        end
        else if (wr_en)
        begin
            alpha_reg <= wval;
            lg_reg    <= LOG_TBL[wval - 8'd1];
            ok_reg    <= (wval >= 8'(MIN_ALPHABET)) && (wval >= 8'd2);
        end
    end

    assign prdata   = {24'd0, alpha_reg};
    assign pready   = 1'b1;
    assign lg       = lg_reg;
    assign alpha_ok = ok_reg;

endmodule

>>> design/pbr_div_cell.sv
// ----------------------------------------------------------------------------
// pbr_div_cell: one restoring division step
// Resolves quotient bit SHIFT and hands the partial remainder on.
// ----------------------------------------------------------------------------
module pbr_div_cell
    import pbr_pkg::*;
#(
    parameter int CW    = 94,
    parameter int SHIFT = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  pbr_ctl_t         ctl_in,
    input  logic [CW-1:0]    rem_in,
    input  logic [CW-1:0]    den_in,
    input  logic [QUO_W-1:0] quo_in,
    output pbr_ctl_t         ctl_out,
    output logic [CW-1:0]    rem_out,
    output logic [CW-1:0]    den_out,
    output logic [QUO_W-1:0] quo_out
);

    pbr_ctl_t         ctl_reg;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    den_reg;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]    dsh;
    logic             ge;

    always_comb
    begin
        dsh      = den_in << SHIFT;
        ge       = (rem_in >= dsh);
        rem_next = ge ? (rem_in - dsh) : rem_in;
        quo_next = quo_in;
        if (ge)
            quo_next[SHIFT] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

>>> sim/pbr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbr_checker: bit rate scoreboard
// Watches both channels, computes the expected rate for each accepted item
// and compares it with the rate that the block returns.
// ----------------------------------------------------------------------------
module pbr_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] correct_count,
    input  logic [15:0] incorrect_count,
    input  logic [39:0] elapsed_micros,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] millibits_per_second,
    input  logic [7:0]  alphabet_now,
    output int          fail_count,
    output int          rates_pending
);

    localparam int FRAC_W = 20;

    logic [31:0] rate_queue[$];

    // log2 with FRAC_W fraction bits, mantissa squared in Q1.31 and truncated
    function automatic logic [63:0] log2_q(input logic [7:0] m);
        logic [63:0] x;
        logic [63:0] frac;
        int          k;
        k = 0;
        while (k < 7 && (m >> (k + 1)) != 0)
            k++;
        x = ({56'd0, m} << 31) >> k;
        frac = 0;
        for (int i = 0; i < FRAC_W; i++)
        begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        return (64'(k) << FRAC_W) | frac;
    endfunction

    function automatic logic [31:0] rate_of(input logic [7:0] alpha, input logic [15:0] c,
                                            input logic [15:0] w, input logic [39:0] us);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        if (alpha < 2 || us == 0 || c <= w)
            return 32'd0;
        num = 128'(log2_q(alpha - 8'd1)) * 128'(c - w) * 128'd1000000000;
        den = 128'(us) << FRAC_W;
        quo = (2 * num + den) / (2 * den);
        return (quo >= 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    endfunction

    assign rates_pending = rate_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                rate_queue.push_back(rate_of(alphabet_now, correct_count,
                                             incorrect_count, elapsed_micros));
            if (out_valid && !out_stall)
            begin
                if (rate_queue.size() == 0)
                begin
                    $display("%0t: unexpected rate, expected none, actual %0d",
                             $time, millibits_per_second);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    logic [31:0] want;
                    want = rate_queue.pop_front();
                    if (want !== millibits_per_second)
                    begin
                        $display("%0t: rate mismatch, expected %0d, actual %0d",
                                 $time, want, millibits_per_second);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> sim/tb_practical_bit_rate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_practical_bit_rate: bit rate regression
// Directed corners then random items over several alphabet sizes, with random
// gaps and stalls, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_practical_bit_rate
    import pbr_pkg::*;
();

    localparam int WATCHDOG = 20000;
    localparam int LATENCY  = 38;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] correct_count = '0;
    logic [15:0] incorrect_count = '0;
    logic [39:0] elapsed_micros = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] millibits_per_second;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // alphabet as the scoreboard should see it
    logic [7:0]  alphabet_now = ALPHABET_RESET;
    int          fail_count;
    int          rates_pending;
    int          idle_pct = 37;   // gap / stall chance in percent
    bit          hold_off = 1'b0; // receiver holds for a long stretch
    int          quiet_cycles = 0;

    always #2 clk = ~clk;

    practical_bit_rate u_dut (.*);

    pbr_checker u_chk (.alphabet_now(alphabet_now), .*);

    // receiver: random stall, plus a long counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    // watchdog: cycles with no accepted item on either side, no hold-off and no APB access
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // APB write: setup then access, done at the edge where penable is high
    task automatic write_alphabet(input logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_ALPHABET; pwdata <= {$urandom} << 8 | value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        alphabet_now = value;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // offer one item with an optional random gap, return once accepted
    task automatic send_item(input logic [15:0] c, input logic [15:0] w,
                             input logic [39:0] us);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        correct_count <= c;
        incorrect_count <= w;
        elapsed_micros <= us;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rates_pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // random item: mostly positive net with realistic times, some noise
    task automatic send_random();
        logic [15:0] c;
        logic [15:0] w;
        logic [39:0] us;
        int          pick;
        pick = $urandom_range(9);
        c = 16'($urandom);
        w = (pick < 7) ? 16'($urandom_range(c)) : 16'($urandom);
        case ($urandom_range(3))
            0: us = 40'({$urandom, $urandom});
            1: us = 40'($urandom_range(1000));
            2: us = 40'($urandom & 32'h03FF_FFFF);
            default: us = (pick == 9) ? 40'd0 : 40'($urandom_range(100000000));
        endcase
        send_item(c, w, us);
    endtask

    initial
    begin
        logic [7:0] alpha_set[8];
        alpha_set = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd36, 8'd128, 8'd200, 8'd255};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners at reset alphabet
        send_item(16'd10, 16'd2, 40'd1000000);
        send_item(16'hFFFF, 16'd0, 40'd1);              // saturates
        send_item(16'hFFFF, 16'd0, 40'hFF_FFFF_FFFF);
        send_item(16'd5, 16'd5, 40'd100);               // no net gain
        send_item(16'd3, 16'd9, 40'd100);
        send_item(16'd100, 16'd1, 40'd0);               // zero time
        send_item(16'd1, 16'd0, 40'hFF_FFFF_FFFF);
        send_item(16'd1, 16'hFFFF, 40'hAA_AAAA_AAAA);
        send_item(16'hAAAA, 16'h5555, 40'h55_5555_5555);
        drain();
        write_alphabet(8'd2);                           // two symbols
        send_item(16'd100, 16'd0, 40'd1000);
        drain();
        write_alphabet(8'd1);                           // small alphabet
        send_item(16'd100, 16'd0, 40'd1000);
        drain();
        write_alphabet(8'd255);
        send_item(16'hFFFF, 16'd0, 40'd1000000);
        send_item(16'd1, 16'd0, 40'd1000000);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            write_alphabet(phase < 8 ? alpha_set[phase] : 8'($urandom));
            idle_pct = (phase == 4) ? 0 : 37;
            for (int n = 0; n < 85; n++)
            begin
                if (phase == 6 && n == 10)
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (200) @(negedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                send_random();
            end
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
design/pbr_pkg.sv
design/pbr_cfg.sv
design/pbr_div_cell.sv
design/practical_bit_rate.sv
sim/pbr_checker.sv
sim/tb_practical_bit_rate.sv
